// ===== rtl/sphere_pontoon_buoyancy_force_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SPHERE_PONTOON_BUOYANCY_FORCE_UNIT_ASSERT_SVH
`define SPHERE_PONTOON_BUOYANCY_FORCE_UNIT_ASSERT_SVH

// same-cycle implication
`define SPBF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPBF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spbf_pkg.sv =====
package spbf_pkg;

    // register indices
    localparam logic [2:0] CFG_BUOY_GAIN  = 3'd0;
    localparam logic [2:0] CFG_DEEP_GAIN  = 3'd1;
    localparam logic [2:0] CFG_LIN_DAMP   = 3'd2;
    localparam logic [2:0] CFG_QUAD_DAMP  = 3'd3;
    localparam logic [2:0] CFG_FORCE_LIM  = 3'd4;

    // round(pi/3 * 2^32)
    localparam logic [32:0] PI_THIRD_Q32 = 33'd4497679235;

    // stage map
    localparam int ST_SAT   = 1;
    localparam int ST_CUBE  = 2;
    localparam int ST_VPP   = 3;
    localparam int ST_VSUM  = 4;
    localparam int ST_VPROD = 5;
    localparam int ST_Q     = 6;
    localparam int ST_KPP   = 7;
    localparam int ST_KSUM  = 8;
    localparam int ST_KTOT  = 9;
    localparam int ST_VOL   = 10;
    localparam int ST_DIV0  = 4;
    localparam int ST_DIVL  = 34;
    localparam int ST_BLEND = 35;
    localparam int ST_COEFP = 36;
    localparam int ST_FPP   = 37;
    localparam int ST_FSUM  = 38;
    localparam int ST_FPROD = 39;
    localparam int ST_F1    = 40;
    localparam int ST_RAW   = 41;
    localparam int ST_LPP   = 42;
    localparam int ST_LSUM  = 43;
    localparam int ST_OUT   = 44;
    localparam int NUM_ST   = 45;

    typedef struct packed {
        logic         inw;
        logic [31:0]  imms;
        logic [30:0]  r;
        logic [33:0]  imm;
        logic [30:0]  sc;
        logic [61:0]  linp;
        logic [61:0]  vvp;
        logic [62:0]  qp0;
        logic [60:0]  qp1;
        logic [92:0]  qsum;
        logic [63:0]  quad;
        logic [63:0]  damp;
        logic [31:0]  s;
        logic [32:0]  h;
        logic [30:0]  d;
        logic [63:0]  ss;
        logic [63:0]  vp0;
        logic [63:0]  vp1;
        logic [63:0]  hterm;
        logic [95:0]  vsum;
        logic [96:0]  vprod;
        logic [47:0]  q;
        logic         qsat;
        logic [63:0]  kp0;
        logic [47:0]  kp1;
        logic [79:0]  ksum;
        logic [80:0]  ktot;
        logic [47:0]  vol;
        logic [61:0]  nd;
        logic [30:0]  rem;
        logic [30:0]  quo;
        logic [31:0]  blend;
        logic [62:0]  coefp;
        logic [63:0]  fp0;
        logic [61:0]  fp1;
        logic [47:0]  fp2;
        logic [45:0]  fp3;
        logic [93:0]  flo;
        logic [77:0]  fhi;
        logic [109:0] fprod;
        logic [63:0]  f1;
        logic [63:0]  raw;
        logic         go;
        logic [62:0]  lp0;
        logic [62:0]  lp1;
        logic [94:0]  lprod;
        logic [47:0]  cvol;
        logic [31:0]  dout;
        logic [30:0]  lift;
    } t_pl;

endpackage

// ===== rtl/sphere_pontoon_buoyancy_force_unit.sv =====
// Spherical pontoon buoyancy with drag, fully pipelined: one query is taken per clock while
// the output register is not holding an untaken result. Most of the pipe is the
// 31-stage restoring divider (one quotient bit per stage) that blends the buoyancy gain
// towards the deep-water gain; the cap volume and the damping are worked out alongside it,
// and the force chain follows. The whole pipe freezes while the output register holds a
// result that has not been taken, so nothing is dropped or repeated. Configuration writes
// land at once and should only be made while the pipe is empty. Values are signed fixed
// point with FRAC_BITS fraction bits (volume unsigned, 32 integer bits); every result
// saturates, and a dry pontoon reports zero volume, damping and force.
module sphere_pontoon_buoyancy_force_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data,
    // query requests
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_center_height,
    input  logic [30:0] i_sphere_radius,
    input  logic [31:0] i_water_level,
    input  logic [31:0] i_vertical_speed,
    input  logic [31:0] i_scale_factor,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_in_water,
    output logic [31:0] o_immersion,
    output logic [47:0] o_cap_volume,
    output logic [31:0] o_damping,
    output logic [30:0] o_lift_force
);
    import spbf_pkg::*;

    localparam logic [30:0] ONE   = 31'(1) << FRAC_BITS;
    localparam logic [31:0] ONE32 = {1'b0, ONE};

    // configuration registers
    logic [30:0] r_bg, r_dwg, r_ld, r_qd, r_fl;
    logic [30:0] w_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg  <= ONE;
            r_dwg <= ONE;
            r_ld  <= '0;
            r_qd  <= '0;
            r_fl  <= 31'h7FFF_FFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BUOY_GAIN: r_bg  <= i_cfg_data;
                CFG_DEEP_GAIN: r_dwg <= i_cfg_data;
                CFG_LIN_DAMP:  r_ld  <= i_cfg_data;
                CFG_QUAD_DAMP: r_qd  <= i_cfg_data;
                CFG_FORCE_LIM: r_fl  <= i_cfg_data;
                default: ;     // unmapped index: ignored
            endcase
        end
    end

    // deep-water gain floored at 1.0, less 1.0
    assign w_m1 = (r_dwg < ONE) ? '0 : r_dwg - ONE;

    // pipeline
    t_pl  r_pl [NUM_ST];
    t_pl  n_pl [NUM_ST];
    logic [NUM_ST-1:0] r_vld;
    logic [NUM_ST-1:0] n_vld;
    logic w_en;

    // global advance: move unless the output holds an untaken result
    assign w_en       = !r_vld[ST_OUT] || i_out_ready;
    assign o_in_ready = w_en;

    // stage 0: radius floor, immersion depth, velocity products
    always_comb begin
        t_pl         p;
        logic [30:0] r1;
        logic [30:0] uv;
        p  = '0;
        r1 = (i_sphere_radius == '0) ? 31'd1 : i_sphere_radius;
        uv = i_vertical_speed[31] ? '0 : i_vertical_speed[30:0];
        p.r    = r1;
        p.imm  = {{2{i_water_level[31]}}, i_water_level}
               - {{2{i_center_height[31]}}, i_center_height}
               + {3'b000, r1};
        p.sc   = i_scale_factor[31] ? '0 : i_scale_factor[30:0];
        p.linp = r_ld * uv;
        p.vvp  = uv * uv;
        n_pl[0]  = p;
        n_vld[0] = i_in_valid;
    end

    for (genvar k = 1; k < NUM_ST; k++) begin : g_st
        localparam int DB = (k >= ST_DIV0 && k <= ST_DIVL) ? ST_DIVL - k : 0;

        always_comb begin
            t_pl          p;
            logic [61:0]  vv;
            logic [30:0]  rem_in;
            logic [31:0]  trial;
            logic [64:0]  dsum;
            logic [61:0]  coef;
            logic [94:0]  lt;
            p      = r_pl[k-1];
            vv     = p.vvp >> FRAC_BITS;
            rem_in = '0;
            trial  = '0;
            dsum   = '0;
            coef   = '0;
            lt     = '0;

            if (k == ST_SAT) begin
                p.inw = ($signed(p.imm) > 34'sd0);
                if (!p.imm[33] && (p.imm[32] || p.imm[31])) begin
                    p.imms = 32'h7FFF_FFFF;
                end else if (p.imm[33] && !(p.imm[32] && p.imm[31])) begin
                    p.imms = 32'h8000_0000;
                end else begin
                    p.imms = p.imm[31:0];
                end
                // depth limited to the diameter
                p.s   = ($signed(p.imm) > $signed({2'b00, p.r, 1'b0})) ? {p.r, 1'b0}
                                                                       : p.imm[31:0];
                p.qp0 = r_qd * vv[31:0];
                p.qp1 = r_qd * vv[61:32];
            end

            if (k == ST_CUBE) begin
                p.h    = {2'b00, p.r} + {1'b0, p.r, 1'b0} - {1'b0, p.s};
                p.d    = (p.s > {1'b0, p.r}) ? 31'(p.s - {1'b0, p.r}) : '0;
                p.ss   = p.s * p.s;
                p.qsum = 93'(p.qp0) + {p.qp1, 32'd0};
            end

            if (k == ST_VPP) begin
                p.vp0   = p.ss[31:0] * p.h[31:0];
                p.vp1   = p.ss[63:32] * p.h[31:0];
                p.hterm = p.h[32] ? p.ss : '0;
                p.nd    = w_m1 * p.d;
                p.quad  = ((p.qsum >> (64 + FRAC_BITS)) != '0) ? '1
                                                              : 64'(p.qsum >> FRAC_BITS);
            end

            if (k == ST_VSUM) begin
                p.vsum = 96'(p.vp0) + {p.vp1, 32'd0};
                dsum   = 65'(p.linp >> FRAC_BITS) + 65'(p.quad);
                p.damp = dsum[64] ? '1 : dsum[63:0];
            end

            if (k == ST_VPROD) begin
                p.vprod = 97'(p.vsum) + {1'b0, p.hterm, 32'd0};
            end

            if (k == ST_Q) begin
                p.q    = 48'(p.vprod >> (2 * FRAC_BITS));
                p.qsat = ((p.vprod >> (2 * FRAC_BITS + 48)) != '0);
            end

            if (k == ST_KPP) begin
                p.kp0 = p.q[31:0] * PI_THIRD_Q32[31:0];
                p.kp1 = p.q[47:32] * PI_THIRD_Q32[31:0];
            end

            if (k == ST_KSUM) begin
                p.ksum = 80'(p.kp0) + {p.kp1, 32'd0};
            end

            if (k == ST_KTOT) begin
                p.ktot = 81'(p.ksum) + (PI_THIRD_Q32[32] ? {1'b0, p.q, 32'd0} : 81'd0);
            end

            if (k == ST_VOL) begin
                p.vol = (p.qsat || p.ktot[80]) ? '1 : p.ktot[79:32];
            end

            // restoring divide, one quotient bit per stage
            if (k >= ST_DIV0 && k <= ST_DIVL) begin
                rem_in = (k == ST_DIV0) ? p.nd[61:31] : p.rem;
                trial  = {rem_in, p.nd[DB]};
                if (trial >= {1'b0, p.r}) begin
                    p.rem     = 31'(trial - {1'b0, p.r});
                    p.quo[DB] = 1'b1;
                end else begin
                    p.rem = trial[30:0];
                end
            end

            if (k == ST_BLEND) begin
                p.blend = ONE32 + {1'b0, p.quo};
            end

            if (k == ST_COEFP) begin
                p.coefp = r_bg * p.blend;
            end

            if (k == ST_FPP) begin
                coef  = 62'(p.coefp >> FRAC_BITS);
                p.fp0 = p.vol[31:0] * coef[31:0];
                p.fp1 = p.vol[31:0] * coef[61:32];
                p.fp2 = p.vol[47:32] * coef[31:0];
                p.fp3 = p.vol[47:32] * coef[61:32];
            end

            if (k == ST_FSUM) begin
                p.flo = 94'(p.fp0) + {p.fp1, 32'd0};
                p.fhi = 78'(p.fp2) + {p.fp3, 32'd0};
            end

            if (k == ST_FPROD) begin
                p.fprod = 110'(p.flo) + {p.fhi, 32'd0};
            end

            if (k == ST_F1) begin
                p.f1 = ((p.fprod >> (64 + FRAC_BITS)) != '0) ? '1
                                                             : 64'(p.fprod >> FRAC_BITS);
            end

            if (k == ST_RAW) begin
                p.go  = p.inw && (p.sc != '0) && (p.f1 > p.damp);
                p.raw = p.f1 - p.damp;
            end

            if (k == ST_LPP) begin
                p.lp0 = p.raw[31:0] * p.sc;
                p.lp1 = p.raw[63:32] * p.sc;
            end

            if (k == ST_LSUM) begin
                p.lprod = 95'(p.lp0) + {p.lp1, 32'd0};
            end

            if (k == ST_OUT) begin
                lt     = p.lprod >> FRAC_BITS;
                p.lift = !p.go ? '0 : ((lt > 95'(r_fl)) ? r_fl : lt[30:0]);
                p.cvol = p.inw ? p.vol : '0;
                if (!p.inw) begin
                    p.dout = '0;
                end else if (p.damp >= 64'h8000_0000) begin
                    p.dout = 32'h8000_0000;
                end else begin
                    p.dout = 32'(32'd0 - p.damp[31:0]);
                end
            end

            n_pl[k]  = p;
            n_vld[k] = r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pl <= n_pl;
        end
    end

    assign o_out_valid  = r_vld[ST_OUT];
    assign o_in_water   = r_pl[ST_OUT].inw;
    assign o_immersion  = r_pl[ST_OUT].imms;
    assign o_cap_volume = r_pl[ST_OUT].cvol;
    assign o_damping    = r_pl[ST_OUT].dout;
    assign o_lift_force = r_pl[ST_OUT].lift;

endmodule

// ===== rtl/spbf_checker.sv =====
`include "sphere_pontoon_buoyancy_force_unit_assert.svh"

module spbf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_ready,
    input logic        o_out_valid,
    input logic        o_in_water,
    input logic [31:0] o_immersion,
    input logic [47:0] o_cap_volume,
    input logic [31:0] o_damping,
    input logic [30:0] o_lift_force
);

    `SPBF_ASSERT_IMP(a_damp_nonpos, i_clk, i_rst_n, o_out_valid, (o_damping == 32'd0) || o_damping[31], "damping positive")
    `SPBF_ASSERT_IMP(a_dry_zero, i_clk, i_rst_n, o_out_valid && !o_in_water, (o_cap_volume == 48'd0) && (o_damping == 32'd0) && (o_lift_force == 31'd0), "dry pontoon gave nonzero result")
    `SPBF_ASSERT_IMP(a_wet_flag, i_clk, i_rst_n, o_out_valid, o_in_water == (!o_immersion[31] && (o_immersion != 32'd0)), "in-water flag disagrees with depth")
    `SPBF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_lift_force) && $stable(o_cap_volume), "stalled result changed")

endmodule

bind sphere_pontoon_buoyancy_force_unit spbf_checker u_spbf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_ready  (i_out_ready),
    .o_out_valid  (o_out_valid),
    .o_in_water   (o_in_water),
    .o_immersion  (o_immersion),
    .o_cap_volume (o_cap_volume),
    .o_damping    (o_damping),
    .o_lift_force (o_lift_force)
);
